### src/fds_pkg.sv
// Shared types, register codes and the exponential table generator for the
// feedback delay saturation unit. No dependencies.
package fds_pkg;

    // Sample formats
    typedef logic signed [23:0] sample_in_t;   // Q1.23
    typedef logic signed [24:0] sample_out_t;  // Q2.23
    typedef logic [24:0]        exp_word_t;    // 2^-t in units of 2^-24
    typedef logic [15:0]        cfg_word_t;

    // Configuration register indexes
    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_GAIN  = 1'b1;

    // Register reset values
    localparam cfg_word_t DELAY_RST = 16'd35280;
    localparam cfg_word_t GAIN_RST  = 16'd45875;

    // +1.0 and -1.0 in Q2.23
    localparam sample_out_t Q23_POS = 25'sh080_0000;
    localparam sample_out_t Q23_NEG = 25'sh180_0000;

    // Width of the quotient of a 16-bit delay by the smallest store depth
    localparam int DQ_W = 7;

    // Integer square root of a 64-bit value, two bits per step
    function automatic longint unsigned isqrt64(longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Table entry i of 2^(-i/size), built from repeated square roots of 0.5
    function automatic exp_word_t exp_entry(int unsigned size, int unsigned i);
        longint unsigned g [33];
        longint unsigned num;
        longint unsigned rem;
        longint unsigned f;
        longint unsigned acc;
        if (i >= size) begin
            return 25'h080_0000;
        end
        g[0] = 64'd1 << 31;
        for (int k = 1; k <= 32; k++) begin
            g[k] = isqrt64(g[k-1] << 32);
        end
        // f = floor(i * 2^32 / size) by long division
        num = longint'(i) << 32;
        rem = 64'd0;
        f   = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            f   = f << 1;
            if (rem >= longint'(size)) begin
                rem = rem - longint'(size);
                f   = f | 64'd1;
            end
        end
        acc = 64'd1 << 32;
        for (int k = 1; k <= 32; k++) begin
            if (((f >> (32 - k)) & 64'd1) != 64'd0) begin
                acc = (acc * g[k] + (64'd1 << 31)) >> 32;
            end
        end
        return exp_word_t'((acc + 64'd128) >> 8);
    endfunction

endpackage

### src/fds_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fds_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/feedback_delay_saturation_unit.sv
// Feedback echo with soft saturation: top level.
// Depends on fds_pkg and fds_ram.
//
// Usage:
//   Input words (s_sample_in, Q1.23) arrive on s_valid/s_ready, one output
//   word (m_sample_out, Q2.23) leaves on m_valid/m_ready per input word.
//   delay_samples (index 0) and feedback_gain (index 1, Q0.16) are written
//   through cfg_wr_en/cfg_index/cfg_wdata while no word is in flight.
// Sequence:
//   m_valid is registered after the emit state. A new word is taken in
//   the idle or feedback state only: the held echo value of one word feeds
//   the saturator of the next in a loop through the table lookup, the
//   interpolation multiply, the delay store read and the gain multiply.
// Stalls:
//   The output word sits in its own register, so the next input word is
//   accepted while it waits; that next word holds before its store write
//   until the output register is free.
// Reset:
//   Registers go to their defaults, the held echo and write position clear.
//   The store itself is not swept: a fill count makes every entry that was
//   never written since reset read as zero, so no clearing pass is needed.
module feedback_delay_saturation_unit #(
    parameter int DELAY_DEPTH    = 65536,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  fds_pkg::cfg_word_t   cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fds_pkg::sample_in_t  s_sample_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fds_pkg::sample_out_t m_sample_out
);

    import fds_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = AW + 1;
    localparam int IW = $clog2(EXP_TABLE_SIZE + 1);
    localparam int PW = 23 + IW;
    localparam int RW = 33 - AW;
    localparam int MW = 16 + RW;

    localparam logic [RW-1:0] RECIP    = RW'((64'd1 << 32) / DELAY_DEPTH);
    localparam logic [AW-1:0] WP_LAST  = AW'(DELAY_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F  = FW'(DELAY_DEPTH);
    localparam logic [IW-1:0] TAB_LAST = IW'(EXP_TABLE_SIZE);
    localparam logic [31:0]   DEPTH_W  = 32'(DELAY_DEPTH);
    localparam logic signed [26:0] ONE24   = 27'sd16777216;
    localparam logic signed [26:0] CLIP_HI = 27'sd8388608;
    localparam logic signed [26:0] CLIP_LO = -27'sd8388608;

    // Sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_INTERP = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_FDBK   = 3'd4;

    logic [2:0]        state_reg, state_next;
    cfg_word_t         delay_reg, gain_reg;
    sample_in_t        sin_reg;
    sample_out_t       held_reg, held_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              mvalid_reg, mvalid_next;
    sample_out_t       out_reg;
    exp_word_t         a_reg, diff_reg, e_reg;
    logic [22:0]       r_reg;
    logic              pos_reg, neg_reg;
    logic [DQ_W-1:0]   dq_reg;
    logic [AW-1:0]     dmod_reg;
    logic              fwd_reg, rdok_reg;

    logic              accept, emit_go;

    // Exponential table, built at elaboration
    exp_word_t exp_tab [EXP_TABLE_SIZE + 1];
    for (genvar gi = 0; gi <= EXP_TABLE_SIZE; gi++) begin : g_tab
        assign exp_tab[gi] = exp_entry(EXP_TABLE_SIZE, gi);
    end

    assign s_ready      = (state_reg == ST_IDLE) || (state_reg == ST_FDBK);
    assign accept       = s_valid && s_ready;
    assign emit_go      = (state_reg == ST_EMIT) && (!mvalid_reg || m_ready);
    assign m_valid      = mvalid_reg;
    assign m_sample_out = out_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_EMIT;
            ST_EMIT:   if (emit_go) state_next = ST_FDBK;
            ST_FDBK:   state_next = accept ? ST_LOOK : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Lookup stage: saturator branch, table index and fraction, delay quotient
    logic              pos_c, neg_c;
    sample_out_t       held_neg;
    logic [23:0]       t_val;
    logic [PW-1:0]     p_val;
    logic [IW-1:0]     idx_a, idx_b;
    exp_word_t         tab_a;
    logic [MW-1:0]     dprod;

    assign pos_c    = !held_reg[24] && (held_reg != '0) && (held_reg <= Q23_POS);
    assign neg_c    = (held_reg == '0) || (held_reg[24] && (held_reg >= Q23_NEG));
    assign held_neg = -held_reg;
    assign t_val    = pos_c ? held_reg[23:0] : (neg_c ? held_neg[23:0] : 24'd0);
    assign p_val    = PW'(t_val) * PW'(EXP_TABLE_SIZE);
    assign idx_a    = p_val[PW-1:23];
    assign idx_b    = (idx_a == TAB_LAST) ? idx_a : idx_a + 1'b1;
    assign tab_a    = exp_tab[idx_a];
    assign dprod    = MW'(delay_reg) * MW'(RECIP);

    // Interpolation stage, delay reduced modulo the store depth
    logic [47:0]       interp_prod;
    logic [31:0]       rem_w, rem_fix;

    assign interp_prod = 48'(diff_reg) * 48'(r_reg);
    assign rem_w       = 32'(delay_reg) - 32'(dq_reg) * DEPTH_W;
    assign rem_fix     = (rem_w >= DEPTH_W) ? rem_w - DEPTH_W : rem_w;

    // Emit stage: saturate, clamp, add input, store write and delayed read
    logic signed [26:0] e_s, gadd, y_w;
    sample_out_t        y_val, sum_val;
    logic [AW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic [FW-1:0]      fill_inc;

    assign e_s     = $signed({2'b00, e_reg});
    assign gadd    = pos_reg ? (ONE24 - e_s) : (neg_reg ? (e_s - ONE24) : 27'sd0);
    assign y_w     = {{2{held_reg[24]}}, held_reg} + gadd;
    assign y_val   = (y_w > CLIP_HI) ? Q23_POS :
                     ((y_w < CLIP_LO) ? Q23_NEG : y_w[24:0]);
    assign sum_val = y_val + {sin_reg[23], sin_reg};
    assign wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
    assign rd_sum  = {1'b0, wp_next} + (AW+1)'(DELAY_DEPTH) - {1'b0, dmod_reg};
    assign rd_addr = (rd_sum >= (AW+1)'(DELAY_DEPTH)) ?
                     AW'(rd_sum - (AW+1)'(DELAY_DEPTH)) : rd_sum[AW-1:0];
    assign fill_inc  = (fill_reg == DEPTH_F) ? fill_reg : fill_reg + 1'b1;
    assign fill_next = emit_go ? fill_inc : fill_reg;

    // Delay store
    logic [24:0] rd_data;

    fds_ram #(
        .WIDTH (25),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (emit_go),
        .wr_addr (wp_next),
        .wr_data (sum_val),
        .rd_en   (emit_go),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Feedback stage: scale the delayed word by the gain, floor
    sample_out_t        fb_src;
    logic signed [41:0] fb_prod;

    assign fb_src    = fwd_reg ? out_reg : (rdok_reg ? $signed(rd_data) : '0);
    assign fb_prod   = $signed({{17{fb_src[24]}}, fb_src}) * $signed({26'd0, gain_reg});
    assign held_next = (state_reg == ST_FDBK) ? fb_prod[40:16] : held_reg;

    assign mvalid_next = emit_go ? 1'b1 : (m_ready ? 1'b0 : mvalid_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            delay_reg  <= DELAY_RST;
            gain_reg   <= GAIN_RST;
            held_reg   <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            fill_reg   <= fill_next;
            mvalid_reg <= mvalid_next;
            if (emit_go) begin
                wp_reg <= wp_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DELAY: delay_reg <= cfg_wdata;
                    CFG_GAIN:  gain_reg  <= cfg_wdata;
                    default:   ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sin_reg <= s_sample_in;
        end
        if (state_reg == ST_LOOK) begin
            a_reg    <= tab_a;
            diff_reg <= tab_a - exp_tab[idx_b];
            r_reg    <= p_val[22:0];
            pos_reg  <= pos_c;
            neg_reg  <= neg_c;
            dq_reg   <= DQ_W'(dprod >> 32);
        end
        if (state_reg == ST_INTERP) begin
            e_reg    <= a_reg - interp_prod[47:23];
            dmod_reg <= AW'(rem_fix);
        end
        if (emit_go) begin
            out_reg  <= sum_val;
            fwd_reg  <= (dmod_reg == '0);
            rdok_reg <= ({1'b0, dmod_reg} < fill_inc) || (fill_inc == DEPTH_F);
        end
    end

`ifndef SYNTHESIS
    // Fill count saturates at the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("fill count beyond store depth");

    // Feedback stage always follows a completed emit
    a_fdbk_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FDBK) |-> $past(state_reg == ST_EMIT))
        else $error("feedback stage without emit");

    // A new output word only comes out of the emit stage
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output word raised outside emit");

    // Write position moves only with a store write
    a_wp_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg != $past(wp_reg)) |-> $past(emit_go))
        else $error("write position moved without a write");

    // Reduced delay stays inside the store
    a_dmod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ({1'b0, dmod_reg} < DEPTH_F))
        else $error("reduced delay out of range");
`endif

endmodule

### verif/feedback_delay_saturation_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for feedback_delay_saturation_unit: directed and random input words,
// an in-bench echo/saturator predictor and an in-order check of every output word.
// Depends on fds_pkg and the unit RTL.
module feedback_delay_saturation_unit_tb;
    import fds_pkg::*;

    localparam int     STORE_DEPTH = 65536;
    localparam int     TAB_SIZE    = 256;
    localparam int     PHASE_WORDS = 163;
    localparam int     CYCLE_LIMIT = 600000;
    localparam longint ONE_Q23     = 64'sd8388608;
    localparam longint ONE_Q24     = 64'sd16777216;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = CFG_DELAY;
    cfg_word_t   cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    sample_in_t  s_sample_in = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    sample_out_t m_sample_out;

    feedback_delay_saturation_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out)
    );

    always #6 aclk = ~aclk;

    // Predictor state: pow table, echo store, write position, held echo, registers
    longint unsigned pow_tab [TAB_SIZE+1];
    sample_out_t     echo_mem [STORE_DEPTH];
    logic [15:0]     wr_pos;
    sample_out_t     held_echo;
    cfg_word_t       delay_reg;
    cfg_word_t       gain_reg;

    sample_out_t     expected_out [$];
    sample_in_t      pending_in [$];
    sample_out_t     want_out;
    bit              calm = 1'b0;
    int unsigned     cycles = 0;
    int              errors = 0;

    // 2^-t for t in [0,1] (Q.23), units of 2^-24, linear interpolation
    function automatic longint pow2_neg(longint t);
        longint unsigned p, idx, frac, a, b;
        p    = t * TAB_SIZE;
        idx  = p >> 23;
        frac = p & 64'h7F_FFFF;
        if (idx >= TAB_SIZE) return longint'(pow_tab[TAB_SIZE]);
        a = pow_tab[idx];
        b = pow_tab[idx + 1];
        return longint'(a - (((a - b) * frac) >> 23));
    endfunction

    // One sample through saturator, store write, delayed read and gain
    function automatic sample_out_t echo_step(sample_in_t smp);
        longint      x, y, sum, prod;
        logic [15:0] rd_pos;
        x = held_echo;
        y = x;
        if (x > 0 && x <= ONE_Q23) y = x + (ONE_Q24 - pow2_neg(x));
        else if (x <= 0 && x >= -ONE_Q23) y = x + (pow2_neg(-x) - ONE_Q24);
        if (y > ONE_Q23) y = ONE_Q23;
        else if (y < -ONE_Q23) y = -ONE_Q23;
        sum = y + longint'(smp);
        wr_pos = wr_pos + 16'd1;
        echo_mem[wr_pos] = sample_out_t'(sum);
        // 16-bit wrap gives the modulo of the store depth
        rd_pos = wr_pos - delay_reg;
        prod = longint'(echo_mem[rd_pos]) * longint'({1'b0, gain_reg});
        held_echo = sample_out_t'(prod >>> 16);
        return sample_out_t'(sum);
    endfunction

    // Mix of extremes, small values near zero and full-range noise
    function automatic sample_in_t rand_sample();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 24'sh7F_FFFF : 24'sh80_0000;
            1, 2: return sample_in_t'($signed($urandom_range(2047)) - 1024);
            default: return sample_in_t'($urandom);
        endcase
    endfunction

    // Append one word to the send queue
    task automatic queue_word(sample_in_t w);
        pending_in = {pending_in, w};
    endtask

    task automatic wait_idle();
        while (pending_in.size() != 0 || s_valid || expected_out.size() != 0)
            @(posedge aclk);
        // let the last word drain out of the pipeline
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_regs(cfg_word_t dly, cfg_word_t gn);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DELAY;
        cfg_wdata <= dly;
        @(posedge aclk);
        cfg_index <= CFG_GAIN;
        cfg_wdata <= gn;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        delay_reg = dly;
        gain_reg  = gn;
    endtask

    // Driver: feeds pending words, predicts on each accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_out = {expected_out, echo_step(s_sample_in)};
            end
            if (!s_valid || s_ready) begin
                if (pending_in.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
                    s_valid     <= 1'b1;
                    s_sample_in <= pending_in.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, in-order compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("sample_out: unexpected word, actual %0d", m_sample_out);
                    errors++;
                end else begin
                    want_out = expected_out.pop_front();
                    if (m_sample_out !== want_out) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want_out, m_sample_out);
                        errors++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= 35;
        end
    end

    always @(posedge aclk) cycles <= cycles + 1;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        longint unsigned gk [33];
        longint unsigned n, r, bt, f, acc;
        cfg_word_t       dly, gn;

        // Table of 2^(-i/256) from repeated square roots of one half
        gk[0] = 64'd1 << 31;
        for (int k = 1; k <= 32; k++) begin
            n  = gk[k-1] << 32;
            r  = 64'd0;
            bt = 64'd1 << 62;
            while (bt > n) bt = bt >> 2;
            while (bt != 64'd0) begin
                if (n >= r + bt) begin
                    n = n - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            gk[k] = r;
        end
        for (int i = 0; i < TAB_SIZE; i++) begin
            f   = (longint'(i) << 32) / TAB_SIZE;
            acc = 64'd1 << 32;
            for (int k = 1; k <= 32; k++) begin
                if (((f >> (32 - k)) & 64'd1) != 64'd0)
                    acc = (acc * gk[k] + (64'd1 << 31)) >> 32;
            end
            pow_tab[i] = (acc + 64'd128) >> 8;
        end
        pow_tab[TAB_SIZE] = 64'd1 << 23;

        foreach (echo_mem[i]) echo_mem[i] = '0;
        wr_pos    = '0;
        held_echo = '0;
        delay_reg = DELAY_RST;
        gain_reg  = GAIN_RST;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: echo is far away, extremes of the input
        queue_word(24'sd0);
        queue_word(24'sh7F_FFFF);
        queue_word(24'sh80_0000);
        queue_word(24'sd1);
        queue_word(-24'sd1);
        wait_idle();

        // Zero delay, full gain: held echo runs past +-1, only clamped
        set_regs(16'd0, 16'hFFFF);
        repeat (3) queue_word(24'sh7F_FFFF);
        repeat (3) queue_word(24'sh80_0000);
        wait_idle();

        // Half gain: negative run lands the held echo exactly on -1
        set_regs(16'd0, 16'h8000);
        repeat (4) queue_word(24'sh80_0000);
        repeat (3) queue_word(24'sh7F_FFFF);
        wait_idle();

        // No feedback, held echo stays at zero
        set_regs(16'd1, 16'd0);
        queue_word(24'sh40_0000);
        queue_word(-24'sh40_0000);
        wait_idle();

        // Longest delay
        set_regs(16'hFFFF, 16'hFFFF);
        queue_word(24'sh12_3456);
        queue_word(24'sh7F_FFFF);
        queue_word(24'sh80_0000);
        wait_idle();

        // Random phases, short delays mostly so the echo comes back often
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 0) dly = cfg_word_t'($urandom);
            else dly = cfg_word_t'($urandom_range(40));
            case ($urandom_range(4))
                0: gn = 16'd0;
                1: gn = 16'hFFFF;
                default: gn = cfg_word_t'($urandom);
            endcase
            if (ph == 9) begin
                dly = DELAY_RST;
                gn  = GAIN_RST;
            end
            set_regs(dly, gn);
            calm = (ph == 2);
            repeat (PHASE_WORDS) queue_word(rand_sample());
            wait_idle();
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### feedback_delay_saturation_unit.f
src/fds_pkg.sv
src/fds_ram.sv
src/feedback_delay_saturation_unit.sv
verif/feedback_delay_saturation_unit_tb.sv
